// ===== rtl/core/hashed_timing_wheel_macros.svh =====
// Assertion macros shared by the timing wheel RTL.
// Depends on nothing; included by the top level only.
`ifndef HASHED_TIMING_WHEEL_MACROS_SVH
`define HASHED_TIMING_WHEEL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timing wheel check failed");

// Next-cycle implication, checked outside reset.
`define HTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timing wheel check failed");

`endif

// ===== rtl/core/htw_pkg.sv =====
`timescale 1ns / 1ps
// Package for the hashed timing wheel: sizes, command codes, types and the
// arming arithmetic. Depends on nothing.
package htw_pkg;

   // Slot count must be a power of two: slots wrap by masking.
   localparam int SLOT_COUNT  = 1024;
   localparam int TIMER_COUNT = 32;
   localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
   localparam int TIMER_IW    = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int INDEX_W     = 5;
   localparam int DELAY_W     = 24;
   localparam int ROT_W       = 14;
   localparam int ROT_MAX     = (1 << ROT_W) - 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_ADJUST = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   typedef enum logic [1:0] {
      CMD_ARM,
      CMD_REMOVE,
      CMD_TICK
   } cmd_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_FLUSH
   } back_state_type;

   typedef struct packed {
      cmd_kind_type          kind;
      logic [TIMER_IW-1:0]   idx;
      logic [DELAY_W-1:0]    delay;
      logic                  periodic;
   } cmd_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  home;
      logic [ROT_W-1:0]      rot;
      logic [DELAY_W-1:0]    delay;
      logic                  periodic;
   } entry_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0]  home;
      logic [ROT_W-1:0]      rot;
   } arm_type;

   typedef struct packed {
      logic                  busy;
      logic                  pend_valid;
   } bk_status_type;

   // Home slot and rotation count for a delay taken from the given slot.
   function automatic arm_type arm_calc(input logic [DELAY_W-1:0]   delay,
                                        input logic [SLOT_BITS-1:0] cur);
      arm_type              r;
      logic [DELAY_W-1:0]   sum;
      logic [DELAY_W-1:0]   rot_full;
      sum      = DELAY_W'(cur) + delay;
      rot_full = delay >> SLOT_BITS;
      r.home   = sum[SLOT_BITS-1:0];
      if (rot_full > DELAY_W'(ROT_MAX)) begin
         r.rot = ROT_W'(ROT_MAX);
      end else begin
         r.rot = rot_full[ROT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/htw_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module htw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/htw_front.sv =====
`timescale 1ns / 1ps
// Front end of the timing wheel: accepts request words, decodes and
// classifies them into queue commands. Depends on htw_pkg.
module htw_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [4:0]               req_timer_index,
   input  logic [23:0]              req_timeout_ticks,
   input  logic                     req_periodic,
   input  logic                     q_full,
   output logic                     push,
   output htw_pkg::cmd_type         push_cmd
);
   import htw_pkg::*;

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;
   cmd_type decoded;
   logic    keep;
   logic    accept;

   // Classify the word; commands naming a timer beyond the table are dropped.
   always_comb begin
      decoded.idx      = TIMER_IW'(req_timer_index);
      decoded.delay    = (req_timeout_ticks == '0) ? DELAY_W'(1) : req_timeout_ticks;
      decoded.periodic = req_periodic;
      unique case (req_op)
         OP_ADD, OP_ADJUST: decoded.kind = CMD_ARM;
         OP_REMOVE:         decoded.kind = CMD_REMOVE;
         OP_TICK:           decoded.kind = CMD_TICK;
         default:           decoded.kind = CMD_TICK;
      endcase
      keep = (req_op == OP_TICK) || (32'(req_timer_index) < TIMER_COUNT);
   end

   assign push      = valid_ff && !q_full;
   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push_cmd  = cmd_ff;

   always_comb begin
      if (accept) begin
         valid_in = keep;
         cmd_in   = decoded;
      end else begin
         valid_in = valid_ff && !push;
         cmd_in   = cmd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

// ===== rtl/core/htw_queue.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back ends of the timing wheel.
// Depends on htw_pkg.
module htw_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  htw_pkg::cmd_type      push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  valid,
   output htw_pkg::cmd_type      head
);
   import htw_pkg::*;

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/htw_back.sv =====
`timescale 1ns / 1ps
// Back end of the timing wheel: executes queued commands, scans the timer
// table on a tick and drives the result words. Depends on htw_pkg, htw_ram.
module htw_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  htw_pkg::cmd_type         q_cmd,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [4:0]               rsp_fired_timer,
   output logic                     rsp_last,
   output htw_pkg::bk_status_type   status
);
   import htw_pkg::*;

   back_state_type             state_ff, state_in;
   logic [SLOT_BITS-1:0]       cur_ff, cur_in;
   logic [TIMER_COUNT-1:0]     armed_ff, armed_in;
   logic [TIMER_IW-1:0]        scan_ff, scan_in;
   logic [TIMER_IW-1:0]        pend_ff, pend_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [TIMER_IW-1:0]        fired_ff, fired_in;
   logic                       last_ff, last_in;

   logic                       wr_en, rd_en;
   logic [TIMER_IW-1:0]        wr_addr, rd_addr;
   entry_type                  wr_entry, entry;
   logic [$bits(entry_type)-1:0] rd_data;

   arm_type                    cmd_arm, re_arm;
   logic                       out_free, scan_last, hit, fire, need_emit, step;

   htw_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TIMER_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign entry     = rd_data;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_last = (scan_ff == TIMER_IW'(TIMER_COUNT - 1));
   assign hit       = armed_ff[scan_ff] && (entry.home == cur_ff);
   assign fire      = hit && (entry.rot == '0);
   assign need_emit = fire && pend_valid_ff;
   assign step      = !need_emit || out_free;
   assign cmd_arm   = arm_calc(q_cmd.delay, cur_ff);
   assign re_arm    = arm_calc(entry.delay, cur_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && (q_cmd.kind == CMD_TICK)) begin
               state_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (step && scan_last) begin
               state_in = BK_FLUSH;
            end
         end
         BK_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = scan_ff;
      wr_entry      = entry;
      rd_en         = 1'b0;
      rd_addr       = '0;
      cur_in        = cur_ff;
      armed_in      = armed_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      fired_in      = fired_ff;
      last_in       = last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_cmd.kind)
                  CMD_ARM: begin
                     wr_en             = 1'b1;
                     wr_addr           = q_cmd.idx;
                     wr_entry.home     = cmd_arm.home;
                     wr_entry.rot      = cmd_arm.rot;
                     wr_entry.delay    = q_cmd.delay;
                     wr_entry.periodic = q_cmd.periodic;
                     armed_in[q_cmd.idx] = 1'b1;
                  end
                  CMD_REMOVE: begin
                     armed_in[q_cmd.idx] = 1'b0;
                  end
                  CMD_TICK: begin
                     rd_en         = 1'b1;
                     rd_addr       = '0;
                     scan_in       = '0;
                     pend_valid_in = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_SCAN: begin
            if (step) begin
               if (hit) begin
                  wr_en = 1'b1;
                  if (!fire) begin
                     wr_entry.rot = entry.rot - 1'b1;
                  end else if (entry.periodic) begin
                     wr_entry.home = re_arm.home;
                     wr_entry.rot  = ((re_arm.home == cur_ff) && (re_arm.rot != '0)) ?
                                     re_arm.rot - 1'b1 : re_arm.rot;
                  end else begin
                     armed_in[scan_ff] = 1'b0;
                  end
               end
               if (fire) begin
                  pend_in       = scan_ff;
                  pend_valid_in = 1'b1;
               end
               if (need_emit) begin
                  rsp_valid_in = 1'b1;
                  fired_in     = pend_ff;
                  last_in      = 1'b0;
               end
               if (!scan_last) begin
                  rd_en   = 1'b1;
                  rd_addr = scan_ff + 1'b1;
                  scan_in = scan_ff + 1'b1;
               end
            end
         end
         BK_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               cur_in = cur_ff + 1'b1;
               if (pend_valid_ff) begin
                  rsp_valid_in  = 1'b1;
                  fired_in      = pend_ff;
                  last_in       = 1'b1;
                  pend_valid_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         cur_ff        <= '0;
         armed_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         armed_ff      <= armed_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_ff  <= scan_in;
      pend_ff  <= pend_in;
      fired_ff <= fired_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired_timer   = INDEX_W'(fired_ff);
   assign rsp_last          = last_ff;
   assign status.busy       = (state_ff != BK_IDLE);
   assign status.pend_valid = pend_valid_ff;

endmodule

// ===== rtl/core/hashed_timing_wheel.sv =====
`timescale 1ns / 1ps
// Top level of the hashed timing wheel: front end, command queue and back end.
// Depends on htw_pkg, htw_front, htw_queue, htw_back and the macros header.
//
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  op, timer_index, timeout_ticks, periodic
// rsp_      out        rsp_valid/rsp_stall  fired_timer, last
//
// An add, adjust or remove word is executed by the back end as it leaves the queue.
// A tick scans the whole timer table: the back end reads it one entry per cycle
// through the single read port of its RAM while the result channel does not hold the scan.
// Reset is synchronous; it disarms every timer and puts the slot pointer at zero.
// A stalled result channel holds the scan when a fired timer is found while the
// one before it is still waiting, and holds the end of a tick until the last
// fired timer can be loaded into the output register.
// The front end keeps taking words while the queue has room.

`include "hashed_timing_wheel_macros.svh"

module hashed_timing_wheel (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_op,
   input  logic [4:0]   req_timer_index,
   input  logic [23:0]  req_timeout_ticks,
   input  logic         req_periodic,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [4:0]   rsp_fired_timer,
   output logic         rsp_last
);
   import htw_pkg::*;

   // Classified commands travel from the front end into the queue.
   logic          push;
   cmd_type       push_cmd;
   logic          q_full;
   // The back end pops one command at a time from the queue head.
   logic          q_valid;
   logic          q_pop;
   cmd_type       q_head;
   bk_status_type bk_status;

   // Front end: registers each word and drops commands for absent timers.
   htw_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_timer_index   (req_timer_index),
      .req_timeout_ticks (req_timeout_ticks),
      .req_periodic      (req_periodic),
      .q_full            (q_full),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   // Queue: lets the front end run on while the back end scans the table.
   htw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   // Back end: owns the slot pointer, the armed bits and the timer table.
   // Fired timers are held one behind the scan so that the last one of a
   // tick can be marked when the scan ends.
   htw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_cmd           (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_fired_timer (rsp_fired_timer),
      .rsp_last        (rsp_last),
      .status          (bk_status)
   );

   // The back end never pops an empty queue, and the front never pushes a full one.
   `HTW_ASSERT_IMPLY(a_pop_nonempty, clock, reset, q_pop, q_valid)
   `HTW_ASSERT_IMPLY(a_push_not_full, clock, reset, push, !q_full)
   // A held fired timer exists only while a tick is being worked.
   `HTW_ASSERT_IMPLY(a_pend_in_tick, clock, reset, bk_status.pend_valid, bk_status.busy)
   // Nothing is popped while the back end is in the middle of a tick.
   `HTW_ASSERT_IMPLY(a_no_pop_busy, clock, reset, bk_status.busy, !q_pop)
   // A tick taken from the queue starts a scan on the next cycle.
   `HTW_ASSERT_NEXT(a_tick_scans, clock, reset, q_pop && (q_head.kind == CMD_TICK), bk_status.busy)

endmodule
